>>> rtl/core/bced_pkg.sv
// ----------------------------------------------------------------------------
// bced_pkg
// Shared types and constants of the four-key button event detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bced_pkg;

  localparam int unsigned NUM_KEYS   = 4;
  localparam int unsigned LEVELS_W   = 4;
  localparam int unsigned KEY_IDX_W  = 2;
  localparam int unsigned FLAGS_W    = 7;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // flag bit positions
  localparam int unsigned FLG_HOLD   = 0;
  localparam int unsigned FLG_DOWN   = 1;
  localparam int unsigned FLG_UP     = 2;
  localparam int unsigned FLG_SINGLE = 3;
  localparam int unsigned FLG_DOUBLE = 4;
  localparam int unsigned FLG_LONG   = 5;
  localparam int unsigned FLG_REPEAT = 6;

  localparam logic [FLAGS_W-1:0] MASK_HOLD_ONLY = FLAGS_W'(1) << FLG_HOLD;

  // reset values of the configuration registers
  localparam logic [DIV_W-1:0]   RST_SAMPLE_DIV = DIV_W'(20);
  localparam logic [TIMER_W-1:0] RST_LONG_TICKS = TIMER_W'(1000);
  localparam logic [TIMER_W-1:0] RST_GAP_TICKS  = TIMER_W'(200);
  localparam logic [TIMER_W-1:0] RST_RPT_TICKS  = TIMER_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_DIV = 2'd0,
    REG_LONG_TICKS = 2'd1,
    REG_GAP_TICKS  = 2'd2,
    REG_RPT_TICKS  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_CHECK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [TIMER_W-1:0] long_ticks;
    logic [TIMER_W-1:0] gap_ticks;
    logic [TIMER_W-1:0] rpt_ticks;
  } timing_cfg_t;

  // per-lane control from the top level
  typedef struct packed {
    logic               tick;    // tick transfer: decrement timer
    logic               sample;  // tick that samples key levels
    logic               level;   // sampled key level
    logic               clear;   // clear masked flags
    logic [FLAGS_W-1:0] mask;
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/bced_lane.sv
// ----------------------------------------------------------------------------
// bced_lane
// One key: timer, level, click state machine and event flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bced_lane
  import bced_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire timing_cfg_t        cfg_i,
  input  wire lane_ctrl_t         ctrl_i,
  output logic [FLAGS_W-1:0]      flags_o
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESSED = 3'd1,
    ST_GAP     = 3'd2,
    ST_SECOND  = 3'd3,
    ST_REPEAT  = 3'd4
  } click_state_e;

  click_state_e       state_q, state_d;
  logic [TIMER_W-1:0] timer_q, timer_d, timer_dec;
  logic               level_q, level_d;
  logic [FLAGS_W-1:0] flags_q, flags_d;
  logic               expired;

  always_comb begin
    timer_dec = (timer_q != '0) ? timer_q - TIMER_W'(1) : timer_q;
    expired   = (timer_dec == '0);
    state_d   = state_q;
    timer_d   = timer_q;
    level_d   = level_q;
    flags_d   = flags_q;

    if (ctrl_i.tick) begin
      timer_d = timer_dec;
      if (ctrl_i.sample) begin
        level_d           = ctrl_i.level;
        flags_d[FLG_HOLD] = ctrl_i.level;
        if (ctrl_i.level && !level_q) flags_d[FLG_DOWN] = 1'b1;
        if (!ctrl_i.level && level_q) flags_d[FLG_UP] = 1'b1;

        unique case (state_q)
          ST_IDLE: begin
            if (ctrl_i.level) begin
              timer_d = cfg_i.long_ticks;
              state_d = ST_PRESSED;
            end
          end
          ST_PRESSED: begin
            if (!ctrl_i.level) begin
              timer_d = cfg_i.gap_ticks;
              state_d = ST_GAP;
            end else if (expired) begin
              timer_d           = cfg_i.rpt_ticks;
              flags_d[FLG_LONG] = 1'b1;
              state_d           = ST_REPEAT;
            end
          end
          ST_GAP: begin
            if (ctrl_i.level) begin
              flags_d[FLG_DOUBLE] = 1'b1;
              state_d             = ST_SECOND;
            end else if (expired) begin
              flags_d[FLG_SINGLE] = 1'b1;
              state_d             = ST_IDLE;
            end
          end
          ST_SECOND: begin
            if (!ctrl_i.level) state_d = ST_IDLE;
          end
          ST_REPEAT: begin
            if (!ctrl_i.level) begin
              state_d = ST_IDLE;
            end else if (expired) begin
              timer_d             = cfg_i.rpt_ticks;
              flags_d[FLG_REPEAT] = 1'b1;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
    end else if (ctrl_i.clear) begin
      flags_d = flags_q & ~ctrl_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      timer_q <= '0;
      level_q <= 1'b0;
      flags_q <= '0;
    end else begin
      state_q <= state_d;
      timer_q <= timer_d;
      level_q <= level_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

>>> rtl/core/bced_merge.sv
// ----------------------------------------------------------------------------
// bced_merge
// Picks the queried key's flags, forms the hit and the per-lane clear.
// ----------------------------------------------------------------------------
`default_nettype none

module bced_merge
  import bced_pkg::*;
(
  input  wire logic                 check_i,
  input  wire logic [KEY_IDX_W-1:0] key_index_i,
  input  wire logic [FLAGS_W-1:0]   flag_mask_i,
  input  wire logic [FLAGS_W-1:0]   lane_flags_i [NUM_KEYS],
  output logic                      hit_o,
  output logic [FLAGS_W-1:0]        key_flags_o,
  output logic [NUM_KEYS-1:0]       clear_o
);

  logic [FLAGS_W-1:0]  sel_flags;
  logic [NUM_KEYS-1:0] sel;

  always_comb begin
    sel_flags = '0;
    for (int unsigned k = 0; k < NUM_KEYS; k++) begin
      sel[k] = (32'(key_index_i) == k);
      if (sel[k]) sel_flags = sel_flags | lane_flags_i[k];
    end
  end

  assign key_flags_o = sel_flags;
  assign hit_o       = |(sel_flags & flag_mask_i);

  // a hold-only query leaves the flags alone
  assign clear_o = (check_i && hit_o && (flag_mask_i != MASK_HOLD_ONLY)) ? sel : '0;

endmodule

`default_nettype wire

>>> rtl/core/button_click_event_detector.sv
// ----------------------------------------------------------------------------
// button_click_event_detector
// Single, double, long and auto-repeat press detector for four keys.
// ----------------------------------------------------------------------------
// The result of an input transfer appears in the output register in the next cycle.
// Throughput: one item per cycle when the output register can take it; a tick
//   steps each key lane's timer, a sampling tick its state machine and flags.
// Input is taken whenever the output register is empty or being drained.
// Reset (rst_ni low, asynchronous): all flags, timers and states cleared,
//   registers back to their defaults, output register empty.
`default_nettype none

module button_click_event_detector
  import bced_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  cmd_i,
  input  wire logic [LEVELS_W-1:0]   key_levels_i,
  input  wire logic [KEY_IDX_W-1:0]  key_index_i,
  input  wire logic [FLAGS_W-1:0]    flag_mask_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       hit_o,
  output logic [FLAGS_W-1:0]         key_flags_o
);

  logic [DIV_W-1:0]   div_q;
  timing_cfg_t        tcfg_q;
  logic [DIV_W-1:0]   presc_q, presc_d, presc_inc;
  logic               in_xfer, tick, check, sample;
  lane_ctrl_t         lane_ctrl [NUM_KEYS];
  logic [FLAGS_W-1:0] lane_flags [NUM_KEYS];
  logic               m_hit;
  logic [FLAGS_W-1:0] m_flags;
  logic [NUM_KEYS-1:0] clear;
  logic               out_valid_q;
  logic               hit_q;
  logic [FLAGS_W-1:0] key_flags_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign tick       = in_xfer && (cmd_i == CMD_TICK);
  assign check      = in_xfer && (cmd_i == CMD_CHECK);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q             <= RST_SAMPLE_DIV;
      tcfg_q.long_ticks <= RST_LONG_TICKS;
      tcfg_q.gap_ticks  <= RST_GAP_TICKS;
      tcfg_q.rpt_ticks  <= RST_RPT_TICKS;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SAMPLE_DIV: div_q             <= cfg_wdata_i[DIV_W-1:0];
        REG_LONG_TICKS: tcfg_q.long_ticks <= cfg_wdata_i[TIMER_W-1:0];
        REG_GAP_TICKS:  tcfg_q.gap_ticks  <= cfg_wdata_i[TIMER_W-1:0];
        REG_RPT_TICKS:  tcfg_q.rpt_ticks  <= cfg_wdata_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // sample prescaler
  always_comb begin
    presc_inc = presc_q + DIV_W'(1);
    sample    = tick && (presc_inc >= div_q);
    presc_d   = presc_q;
    if (tick) presc_d = sample ? '0 : presc_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) presc_q <= '0;
    else         presc_q <= presc_d;
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    if (k < LEVELS_W) begin : g_lvl
      assign lane_ctrl[k].level = key_levels_i[k];
    end else begin : g_nolvl
      assign lane_ctrl[k].level = 1'b0;
    end
    assign lane_ctrl[k].tick   = tick;
    assign lane_ctrl[k].sample = sample;
    assign lane_ctrl[k].clear  = clear[k];
    assign lane_ctrl[k].mask   = flag_mask_i;

    bced_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (tcfg_q),
      .ctrl_i  (lane_ctrl[k]),
      .flags_o (lane_flags[k])
    );
  end

  bced_merge u_merge (
    .check_i      (check),
    .key_index_i  (key_index_i),
    .flag_mask_i  (flag_mask_i),
    .lane_flags_i (lane_flags),
    .hit_o        (m_hit),
    .key_flags_o  (m_flags),
    .clear_o      (clear)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hit_q       <= check ? m_hit : 1'b0;
      key_flags_q <= check ? m_flags : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign key_flags_o = key_flags_q;

  a_tick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> (!hit_q && key_flags_q == '0))
    else $error("tick result not zero");

  a_hit_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hit_q) |-> (key_flags_q != '0))
    else $error("hit with empty flag byte");

  a_clear_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(clear) && (clear == '0 || check))
    else $error("bad lane clear vector");

  a_presc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample |=> (presc_q == '0))
    else $error("prescaler did not restart after sample");

endmodule

`default_nettype wire
